// ===== rtl/sfpl_pkg.sv =====
// Package: shared types and constants of the serial flash page loader.
`default_nettype none

package sfpl_pkg;

  localparam int unsigned PageBytesDef = 256;
  localparam int unsigned ResFifoDepth = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [CfgIdxW-1:0] CfgHandshakeTicks   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgByteTimeoutTicks = 2'd1;

  localparam logic [15:0] HandshakeTicksRst   = 16'd3000;
  localparam logic [15:0] ByteTimeoutTicksRst = 16'd500;

  localparam logic [7:0] ByteStart = 8'hF5;
  localparam logic [7:0] BytePage  = 8'hF4;
  localparam logic [7:0] ByteLeave = 8'hFF;

  localparam logic [1:0] RkEcho   = 2'd0;
  localparam logic [1:0] RkFill   = 2'd1;
  localparam logic [1:0] RkCommit = 2'd2;
  localparam logic [1:0] RkLeave  = 2'd3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic [6:0]  word_index;
    logic [15:0] word_data;
    logic [15:0] page_address;
    logic        last;
  } sfpl_res_t;

  typedef struct packed {
    logic      v0;
    logic      v1;
    sfpl_res_t res0;
    sfpl_res_t res1;
  } sfpl_push_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } sfpl_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/sfpl_in_if.sv =====
// Interface: input channel carrying bytes and timer ticks.
`default_nettype none

interface sfpl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfpl_out_if.sv =====
// Interface: result channel of the loader.
`default_nettype none

interface sfpl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic [6:0]  word_index;
  logic [15:0] word_data;
  logic [15:0] page_address;
  logic        last;

  modport source (output valid, output result_kind, output tx_byte, output word_index,
                  output word_data, output page_address, output last, input ready);
  modport sink   (input valid, input result_kind, input tx_byte, input word_index,
                  input word_data, input page_address, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfpl_ctrl.sv =====
// Loader control: input register, mode sequencer and result generation.
`default_nettype none

module sfpl_ctrl import sfpl_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        beat_i,
  input  wire        kind_i,
  input  wire  [7:0] rx_byte_i,
  input  wire  sfpl_cfg_t cfg_i,
  output sfpl_push_t push_o
);

  localparam int unsigned BcW   = $clog2(PAGE_BYTES + 4);
  localparam int unsigned AddrW = 16 + $clog2(PAGE_BYTES + 1);

  localparam logic [1:0] ModeHandshake = 2'd0;
  localparam logic [1:0] ModeCommand   = 2'd1;
  localparam logic [1:0] ModeFrame     = 2'd2;
  localparam logic [1:0] ModeLeft      = 2'd3;

  logic             stg_v_q;
  logic             stg_kind_q;
  logic [7:0]       stg_byte_q;

  logic [15:0]      to_ticks_q, to_ticks_d;
  logic [1:0]       mode_q, mode_d;
  logic [BcW-1:0]   bc_q, bc_d;
  logic [15:0]      ticks_q, ticks_d;
  logic [7:0]       pn_hi_q, pn_hi_d;
  logic [7:0]       pn_lo_q, pn_lo_d;
  logic [7:0]       pend_q, pend_d;

  logic             expire;
  logic [15:0]      ticks_dec;
  logic [BcW-1:0]   off;
  logic [BcW-1:0]   bc_inc;
  logic             done;
  logic [AddrW-1:0] addr_full;
  logic [AddrW-1:0] addr_clamp;
  sfpl_res_t        blank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= beat_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      stg_kind_q <= kind_i;
      stg_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_ticks_q <= ByteTimeoutTicksRst;
      mode_q     <= ModeHandshake;
      bc_q       <= '0;
      ticks_q    <= HandshakeTicksRst;
      pn_hi_q    <= '0;
      pn_lo_q    <= '0;
      pend_q     <= '0;
    end else begin
      to_ticks_q <= to_ticks_d;
      mode_q     <= mode_d;
      bc_q       <= bc_d;
      ticks_q    <= ticks_d;
      pn_hi_q    <= pn_hi_d;
      pn_lo_q    <= pn_lo_d;
      pend_q     <= pend_d;
    end
  end

  assign expire     = (ticks_q <= 16'd1);
  assign ticks_dec  = expire ? 16'd0 : ticks_q - 16'd1;
  assign off        = bc_q - BcW'(2);
  assign bc_inc     = bc_q + BcW'(1);
  assign done       = (bc_inc >= BcW'(PAGE_BYTES + 2));
  assign addr_full  = AddrW'({pn_hi_q, pn_lo_q}) * AddrW'(PAGE_BYTES);
  assign addr_clamp = (addr_full > AddrW'(32'h10000 - PAGE_BYTES)) ?
                      AddrW'(32'h10000 - PAGE_BYTES) : addr_full;
  assign blank      = '0;

  always_comb begin
    to_ticks_d = to_ticks_q;
    mode_d     = mode_q;
    bc_d       = bc_q;
    ticks_d    = ticks_q;
    pn_hi_d    = pn_hi_q;
    pn_lo_d    = pn_lo_q;
    pend_d     = pend_q;
    push_o     = '0;
    push_o.res0 = blank;
    push_o.res1 = blank;

    if (stg_v_q) begin
      case (mode_q)
        ModeHandshake: begin
          if (stg_kind_q) begin
            ticks_d = ticks_dec;
            if (expire) begin
              mode_d                  = ModeLeft;
              push_o.v0               = 1'b1;
              push_o.res0.result_kind = RkLeave;
              push_o.res0.last        = 1'b1;
            end
          end else if (stg_byte_q == ByteStart) begin
            mode_d                  = ModeCommand;
            push_o.v0               = 1'b1;
            push_o.res0.result_kind = RkEcho;
            push_o.res0.tx_byte     = ByteStart;
            push_o.res0.last        = 1'b1;
          end
        end
        ModeCommand: begin
          if (!stg_kind_q) begin
            if (stg_byte_q == ByteStart) begin
              push_o.v0               = 1'b1;
              push_o.res0.result_kind = RkEcho;
              push_o.res0.tx_byte     = ByteStart;
              push_o.res0.last        = 1'b1;
            end else if (stg_byte_q == ByteLeave) begin
              mode_d                  = ModeLeft;
              push_o.v0               = 1'b1;
              push_o.v1               = 1'b1;
              push_o.res0.result_kind = RkEcho;
              push_o.res0.tx_byte     = ByteLeave;
              push_o.res1.result_kind = RkLeave;
              push_o.res1.last        = 1'b1;
            end else if (stg_byte_q == BytePage) begin
              mode_d                  = ModeFrame;
              bc_d                    = '0;
              ticks_d                 = to_ticks_q;
              push_o.v0               = 1'b1;
              push_o.res0.result_kind = RkEcho;
              push_o.res0.tx_byte     = BytePage;
              push_o.res0.last        = 1'b1;
            end
          end
        end
        ModeFrame: begin
          if (stg_kind_q) begin
            ticks_d = ticks_dec;
            if (expire) begin
              mode_d = ModeCommand;
            end
          end else begin
            ticks_d = to_ticks_q;
            if (bc_q == BcW'(0)) begin
              pn_hi_d = stg_byte_q;
              bc_d    = BcW'(1);
            end else if (bc_q == BcW'(1)) begin
              pn_lo_d = stg_byte_q;
              bc_d    = BcW'(2);
            end else begin
              bc_d = bc_inc;
              if (!off[0]) begin
                pend_d = stg_byte_q;
              end else begin
                push_o.v0               = 1'b1;
                push_o.res0.result_kind = RkFill;
                push_o.res0.word_index  = 7'(off >> 1);
                push_o.res0.word_data   = {stg_byte_q, pend_q};
                push_o.res0.last        = !done;
                if (done) begin
                  push_o.v1                = 1'b1;
                  push_o.res1.result_kind  = RkCommit;
                  push_o.res1.page_address = addr_clamp[15:0];
                  push_o.res1.last         = 1'b1;
                  mode_d                   = ModeCommand;
                  bc_d                     = '0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_i.we) begin
      if (cfg_i.index == CfgHandshakeTicks) begin
        if (mode_q == ModeHandshake) begin
          ticks_d = cfg_i.data;
        end
      end else if (cfg_i.index == CfgByteTimeoutTicks) begin
        to_ticks_d = cfg_i.data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfpl_res_fifo.sv =====
// Result queue: takes up to two results a cycle, delivers one beat a cycle while pop_i is high.
`default_nettype none

module sfpl_res_fifo import sfpl_pkg::*; #(
  parameter int unsigned DEPTH = ResFifoDepth
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  sfpl_push_t           push_i,
  input  wire                        pop_i,
  output sfpl_res_t                  head_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned LvlW = $clog2(DEPTH + 1);

  sfpl_res_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [PtrW-1:0] wr_nxt;
  logic            pop;

  assign wr_nxt = wr_q + PtrW'(1);
  assign pop    = pop_i && (lvl_q != '0);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.v0) + PtrW'(push_i.v1);
    rd_d  = rd_q + PtrW'(pop);
    lvl_d = lvl_q + LvlW'(push_i.v0) + LvlW'(push_i.v1) - LvlW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.v1) begin
      mem_q[wr_nxt] <= push_i.res1;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (lvl_q != '0);
  assign level_o = lvl_q;

endmodule

`default_nettype wire

// ===== rtl/serial_flash_page_loader_core.sv =====
// Top level: serial flash page loader core.
`default_nettype none

// Accepts one input beat (serial byte or timer tick) per cycle while input
// ready is high. A beat is registered, decoded in the following cycle, and
// its results are written to an eight-entry result queue whose head drives
// the output channel. A 0xFF command and the byte that completes a page frame
// give two results each; the queue delivers one per cycle while the output
// side is ready. Input ready is high while the queue holds four or fewer
// results, so with the output side taking every beat the block sustains one
// input item per cycle.
module serial_flash_page_loader_core import sfpl_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  sfpl_in_if.sink             in_if,
  sfpl_out_if.source          out_if,
  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_index_i,
  input  wire  [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned LvlW = $clog2(ResFifoDepth + 1);

  sfpl_cfg_t       cfg;
  sfpl_push_t      push;
  sfpl_res_t       head;
  logic            head_v;
  logic [LvlW-1:0] level;
  logic            beat;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  assign in_if.ready = (level <= LvlW'(ResFifoDepth - 4));
  assign beat        = in_if.valid && in_if.ready;

  sfpl_ctrl #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .kind_i    (in_if.kind),
    .rx_byte_i (in_if.rx_byte),
    .cfg_i     (cfg),
    .push_o    (push)
  );

  sfpl_res_fifo #(
    .DEPTH (ResFifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_if.ready),
    .head_o  (head),
    .valid_o (head_v),
    .level_o (level)
  );

  assign out_if.valid        = head_v;
  assign out_if.result_kind  = head.result_kind;
  assign out_if.tx_byte      = head.tx_byte;
  assign out_if.word_index   = head.word_index;
  assign out_if.word_data    = head.word_data;
  assign out_if.page_address = head.page_address;
  assign out_if.last         = head.last;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LvlW'(ResFifoDepth))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v1 |-> push.v0)
    else $error("second result pushed without first");

  a_echo_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.result_kind == RkEcho && !out_if.last) |->
    (out_if.tx_byte == ByteLeave))
    else $error("non-final echo is not the leave byte");

  a_commit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.result_kind == RkCommit || out_if.result_kind == RkLeave)) |->
    out_if.last)
    else $error("commit or leave beat not marked last");

endmodule

`default_nettype wire

// ===== bench/serial_flash_page_loader_core_test.sv =====
// Testbench for the serial flash page loader core: random beats checked against a predictor.
import sfpl_pkg::*;

typedef enum logic [1:0] {LdHandshake, LdCommand, LdFrame, LdLeft} loader_mode_e;

class loader_tracker;
  logic [15:0]  start_window = HandshakeTicksRst;
  logic [15:0]  byte_window  = ByteTimeoutTicksRst;
  loader_mode_e mode         = LdHandshake;
  int unsigned  frame_pos    = 0;
  logic [15:0]  ticks_left   = HandshakeTicksRst;
  logic [7:0]   page_hi      = '0;
  logic [7:0]   page_lo      = '0;
  logic [7:0]   low_byte     = '0;
  sfpl_res_t    due_q[$];
  int unsigned  fail_count   = 0;

  function void post(logic [1:0] kind, logic [7:0] tx, logic [6:0] widx,
                     logic [15:0] wdata, logic [15:0] addr, logic last);
    sfpl_res_t r;
    r.result_kind  = kind;
    r.tx_byte      = tx;
    r.word_index   = widx;
    r.word_data    = wdata;
    r.page_address = addr;
    r.last         = last;
    due_q.push_back(r);
  endfunction

  function bit window_expired();
    if (ticks_left <= 16'd1) begin
      ticks_left = '0;
      return 1'b1;
    end
    ticks_left = ticks_left - 16'd1;
    return 1'b0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    if (idx == CfgHandshakeTicks) begin
      start_window = data;
      if (mode == LdHandshake) ticks_left = data;
    end else if (idx == CfgByteTimeoutTicks) begin
      byte_window = data;
    end
  endfunction

  // returns 0 when the beat is ignored
  function bit note_beat(logic is_tick, logic [7:0] b);
    int unsigned off;
    int unsigned addr;
    int unsigned page_cap;
    bit          done;
    page_cap = 32'h10000 - PageBytesDef;
    case (mode)
      LdHandshake: begin
        if (is_tick) begin
          if (window_expired()) begin
            mode = LdLeft;
            post(RkLeave, '0, '0, '0, '0, 1'b1);
          end
          return 1'b1;
        end
        if (b != ByteStart) return 1'b0;
        mode = LdCommand;
        post(RkEcho, ByteStart, '0, '0, '0, 1'b1);
        return 1'b1;
      end
      LdCommand: begin
        if (is_tick) return 1'b0;
        if (b == ByteStart) begin
          post(RkEcho, ByteStart, '0, '0, '0, 1'b1);
        end else if (b == ByteLeave) begin
          mode = LdLeft;
          post(RkEcho, ByteLeave, '0, '0, '0, 1'b0);
          post(RkLeave, '0, '0, '0, '0, 1'b1);
        end else if (b == BytePage) begin
          mode = LdFrame;
          frame_pos = 0;
          ticks_left = byte_window;
          post(RkEcho, BytePage, '0, '0, '0, 1'b1);
        end else begin
          return 1'b0;
        end
        return 1'b1;
      end
      LdFrame: begin
        if (is_tick) begin
          if (window_expired()) mode = LdCommand;
          return 1'b1;
        end
        ticks_left = byte_window;
        if (frame_pos == 0) begin
          page_hi = b;
        end else if (frame_pos == 1) begin
          page_lo = b;
        end else begin
          off = frame_pos - 2;
          if (off[0] == 1'b0) begin
            low_byte = b;
          end else begin
            done = (frame_pos + 1 >= PageBytesDef + 2);
            post(RkFill, '0, 7'(off >> 1), {b, low_byte}, '0, !done);
            if (done) begin
              addr = {page_hi, page_lo} * PageBytesDef;
              if (addr > page_cap) addr = page_cap;
              post(RkCommit, '0, '0, '0, addr[15:0], 1'b1);
              mode = LdCommand;
              frame_pos = 0;
              return 1'b1;
            end
          end
        end
        frame_pos++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function void match_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function void check_result(sfpl_res_t got);
    sfpl_res_t want;
    if (due_q.size() == 0) begin
      $error("result_kind: expected none, got 0x%0h", got.result_kind);
      fail_count++;
      return;
    end
    want = due_q.pop_front();
    match_field("result_kind", want.result_kind, got.result_kind);
    match_field("tx_byte", want.tx_byte, got.tx_byte);
    match_field("word_index", want.word_index, got.word_index);
    match_field("word_data", want.word_data, got.word_data);
    match_field("page_address", want.page_address, got.page_address);
    match_field("last", want.last, got.last);
  endfunction
endclass

module serial_flash_page_loader_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned ItemTarget  = 1650;
  localparam int unsigned IdlePct     = 9;
  localparam int unsigned QuietFrom   = 500;
  localparam int unsigned QuietTo     = 900;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PageSize    = PageBytesDef;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         work_cnt = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         sel;
  logic [15:0]         byte_window_now;
  loader_tracker       tracker;
  sfpl_res_t           got;
  wire                 quiet = (work_cnt >= QuietFrom) && (work_cnt < QuietTo);

  sfpl_in_if  in_ch ();
  sfpl_out_if out_ch ();

  serial_flash_page_loader_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.result_kind  = out_ch.result_kind;
      got.tx_byte      = out_ch.tx_byte;
      got.word_index   = out_ch.word_index;
      got.word_data    = out_ch.word_data;
      got.page_address = out_ch.page_address;
      got.last         = out_ch.last;
      tracker.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("FAIL serial_flash_page_loader_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(logic k, logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    if (tracker.note_beat(k, b)) work_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_beat(1'b1, 8'($urandom));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.due_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    if (idx == CfgByteTimeoutTicks) byte_window_now = data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(0, 3))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'($urandom_range(3, 40));
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 15))
      0: return BytePage;
      1: return ByteStart;
      2: return ByteLeave;
      3: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_page();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h00FF;
      2: return 16'h0100;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // ticks that stay inside the inter-byte timeout
  task automatic gap_ticks();
    int unsigned cap;
    cap = byte_window_now - 1;
    if (cap > 3) cap = 3;
    if (cap != 0 && $urandom_range(0, 99) < 8) repeat ($urandom_range(1, cap)) send_tick();
  endtask

  task automatic send_frame(bit intact);
    logic [15:0] page;
    int unsigned span;
    page = pick_page();
    if (!intact && byte_window_now > 40) begin
      write_reg(CfgByteTimeoutTicks, 16'($urandom_range(1, 8)));
    end
    if (intact) span = PageSize + 2;
    else if ($urandom_range(0, 9) == 0) span = $urandom_range(2, PageSize + 1);
    else span = $urandom_range(0, 12);
    send_beat(1'b0, BytePage);
    for (int unsigned i = 0; i < span; i++) begin
      send_beat(1'b0, (i == 0) ? page[15:8] : (i == 1) ? page[7:0] : pick_data());
      gap_ticks();
    end
    if (!intact) repeat (byte_window_now) send_tick();
  endtask

  task automatic command_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1) == 1) begin
        send_tick();
      end else if ($urandom_range(0, 3) == 0) begin
        send_beat(1'b0, ByteStart);
      end else begin
        b = 8'($urandom);
        while (b == BytePage || b == ByteLeave) b = 8'($urandom);
        send_beat(1'b0, b);
      end
    end
  endtask

  initial begin
    tracker         = new;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = 1'b0;
    in_ch.rx_byte   = '0;
    out_ch.ready    = 1'b0;
    byte_window_now = ByteTimeoutTicksRst;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // start window: reload on write, no expiry, stray bytes
    write_reg(CfgHandshakeTicks, 16'd3);
    send_tick();
    send_tick();
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, BytePage);
    send_beat(1'b0, ByteLeave);
    write_reg(CfgHandshakeTicks, 16'hFFFF);
    send_tick();
    write_reg(CfgSpareA, 16'($urandom));
    write_reg(CfgSpareB, 16'($urandom));
    send_beat(1'b0, ByteStart);

    // command mode, then frames dropped on the shortest timeout
    send_tick();
    send_beat(1'b0, 8'h7E);
    send_beat(1'b0, ByteStart);
    write_reg(CfgHandshakeTicks, 16'd1);
    write_reg(CfgByteTimeoutTicks, 16'd1);
    send_beat(1'b0, BytePage);
    send_beat(1'b0, 8'h12);
    send_tick();
    send_beat(1'b0, BytePage);
    send_tick();
    write_reg(CfgByteTimeoutTicks, 16'hFFFF);
    send_frame(1'b1);

    while (work_cnt < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) write_reg(CfgByteTimeoutTicks, pick_timeout());
      if ($urandom_range(0, 9) == 0) write_reg(CfgHandshakeTicks, pick_timeout());
      if ($urandom_range(0, 19) == 0) write_reg(CfgSpareB, 16'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 65) send_frame(1'b1);
      else if (sel < 85) send_frame(1'b0);
      else command_noise();
    end

    // leave, then beats that must be ignored
    send_beat(1'b0, ByteLeave);
    send_tick();
    send_beat(1'b0, ByteStart);
    send_beat(1'b0, BytePage);
    in_ch.valid <= 1'b0;
    while (tracker.due_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (tracker.fail_count == 0 && tracker.due_q.size() == 0) begin
      $display("PASS serial_flash_page_loader_core");
    end else begin
      $display("FAIL serial_flash_page_loader_core");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/sfpl_pkg.sv
rtl/sfpl_in_if.sv
rtl/sfpl_out_if.sv
rtl/sfpl_ctrl.sv
rtl/sfpl_res_fifo.sv
rtl/serial_flash_page_loader_core.sv
bench/serial_flash_page_loader_core_test.sv
